/* src/lidar_beam_to_grid_cell_unit_defines.svh */
// assertion macros for the beam to grid cell unit
`ifndef LIDAR_BEAM_TO_GRID_CELL_UNIT_DEFINES_SVH
`define LIDAR_BEAM_TO_GRID_CELL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LBGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LBGC_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);
`else
`define LBGC_ASSERT_IMP(lbl, ante, cons, msg)
`define LBGC_ASSERT_DLY(lbl, ante, n, cons, msg)
`endif

`endif

/* src/lbgc_pkg.sv */
// types and constants of the beam to grid cell unit
package lbgc_pkg;

  localparam int MAP_WIDTH_DEF  = 1024;
  localparam int MAP_HEIGHT_DEF = 1024;
  localparam int MAX_BEAMS_DEF  = 4096;

  localparam int CORDIC_STEPS = 14;
  localparam int XW = 19;
  localparam int ZW = 18;
  localparam int CFG_W = 24;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 19'sd39797;
  localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
  };

  typedef enum logic [2:0] {
    CFG_START_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_RANGE_MIN   = 3'd2,
    CFG_RANGE_MAX   = 3'd3,
    CFG_OFFSET_X    = 3'd4,
    CFG_OFFSET_Y    = 3'd5,
    CFG_CELL_SCALE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic [11:0] beam_index;
    logic [15:0] range_value;
    logic        not_finite;
  } beam_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  cell_x;
    logic [9:0]  cell_y;
    logic [19:0] cell_index;
  } result_t;

endpackage

/* src/lidar_beam_to_grid_cell_unit.sv */
// beam to occupancy-grid cell projection, pipelined top level
// One beam may be started in every clock cycle; busy stays low. Each beam gives
// exactly one result, shown with done for one cycle, after these stages: one
// stage for the range check and the index and range products, one for
// the beam angle and quadrant fold, one per CORDIC iteration (14), then sign
// fix, projection multiply, offset add, truncation and map check, and the cell
// index. The receiver cannot stall the unit, so results are never held back.
// Registers are written through cfg_we, cfg_index and cfg_data only while no beam
// is in flight; the user must keep to this, the unit does not enforce it.
`include "lidar_beam_to_grid_cell_unit_defines.svh"

module lidar_beam_to_grid_cell_unit #(
  parameter int MAP_WIDTH  = lbgc_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = lbgc_pkg::MAP_HEIGHT_DEF,
  parameter int MAX_BEAMS  = lbgc_pkg::MAX_BEAMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lbgc_pkg::beam_t            beam,
  output logic                       done,
  output lbgc_pkg::result_t          result,
  input  logic                       cfg_we,
  input  lbgc_pkg::cfg_reg_t         cfg_index,
  input  logic [lbgc_pkg::CFG_W-1:0] cfg_data
);

  localparam int STEPS = lbgc_pkg::CORDIC_STEPS;
  localparam int XW = lbgc_pkg::XW;
  localparam int ZW = lbgc_pkg::ZW;
  localparam int PW = 33 + XW;
  localparam int SW = PW + 1;
  localparam int QW = SW - 32;
  localparam int LATENCY = STEPS + 7;

  // configuration registers
  logic [15:0]        start_angle;
  logic [15:0]        angle_step;
  logic [15:0]        rng_lo;
  logic [15:0]        rng_hi;
  logic signed [23:0] offset_x;
  logic signed [23:0] offset_y;
  logic [15:0]        cell_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step  <= '0;
      rng_lo      <= '0;
      rng_hi      <= 16'hffff;
      offset_x    <= '0;
      offset_y    <= '0;
      cell_scale  <= 16'd5120;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbgc_pkg::CFG_START_ANGLE: start_angle <= cfg_data[15:0];
        lbgc_pkg::CFG_ANGLE_STEP:  angle_step  <= cfg_data[15:0];
        lbgc_pkg::CFG_RANGE_MIN:   rng_lo      <= cfg_data[15:0];
        lbgc_pkg::CFG_RANGE_MAX:   rng_hi      <= cfg_data[15:0];
        lbgc_pkg::CFG_OFFSET_X:    offset_x    <= cfg_data[23:0];
        lbgc_pkg::CFG_OFFSET_Y:    offset_y    <= cfg_data[23:0];
        lbgc_pkg::CFG_CELL_SCALE:  cell_scale  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage a: range check, index and range products
  logic        a_vld;
  logic        a_bad;
  logic [15:0] a_prod;
  logic [31:0] a_dist;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= accept;
  end

  always_ff @(posedge clk) begin
    a_bad  <= beam.not_finite || ({1'b0, beam.beam_index} >= 13'(MAX_BEAMS)) ||
              (beam.range_value < rng_lo) || (beam.range_value > rng_hi);
    a_prod <= 16'({16'b0, beam.beam_index} * {12'b0, angle_step});
    a_dist <= {16'b0, beam.range_value} * {16'b0, cell_scale};
  end

  // stage b and cordic iterations
  logic                 cvld  [STEPS+1];
  logic                 cbad  [STEPS+1];
  logic                 cflip [STEPS+1];
  logic [31:0]          cdist [STEPS+1];
  logic signed [XW-1:0] cx    [STEPS+1];
  logic signed [XW-1:0] cy    [STEPS+1];
  logic signed [ZW-1:0] cz    [STEPS+1];

  logic [15:0] angle;
  logic        fold;
  logic [15:0] zfold;
  assign angle = start_angle + a_prod;
  assign fold  = angle[15] ^ angle[14];
  assign zfold = fold ? {~angle[15], angle[14:0]} : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) cvld[k] <= 1'b0;
    end else begin
      cvld[0] <= a_vld;
      for (int k = 0; k < STEPS; k++) cvld[k+1] <= cvld[k];
    end
  end

  always_ff @(posedge clk) begin
    cbad[0]  <= a_bad;
    cflip[0] <= fold;
    cdist[0] <= a_dist;
    cx[0]    <= lbgc_pkg::CORDIC_GAIN;
    cy[0]    <= '0;
    cz[0]    <= {{(ZW-16){zfold[15]}}, zfold};
    for (int k = 0; k < STEPS; k++) begin
      cbad[k+1]  <= cbad[k];
      cflip[k+1] <= cflip[k];
      cdist[k+1] <= cdist[k];
      if (!cz[k][ZW-1]) begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        cz[k+1] <= cz[k] - lbgc_pkg::ATAN_TURN[k];
      end else begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        cz[k+1] <= cz[k] + lbgc_pkg::ATAN_TURN[k];
      end
    end
  end

  // stage d: undo the half-turn fold
  logic                 d_vld;
  logic                 d_bad;
  logic [31:0]          d_dist;
  logic signed [XW-1:0] d_c;
  logic signed [XW-1:0] d_s;

  // stage e: projection products
  logic                 e_vld;
  logic                 e_bad;
  logic signed [PW-1:0] e_px;
  logic signed [PW-1:0] e_py;

  // stage f: offset add
  logic                 f_vld;
  logic                 f_bad;
  logic signed [SW-1:0] f_sx;
  logic signed [SW-1:0] f_sy;

  // stage g: truncation and map check
  logic         g_vld;
  lbgc_pkg::status_t g_status;
  logic [9:0]   g_u;
  logic [9:0]   g_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      d_vld <= cvld[STEPS];
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
      done  <= g_vld;
    end
  end

  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  logic          out_x;
  logic          out_y;
  logic          g_hit;

  always_comb begin
    qx = f_sx[SW-1:32] + QW'(f_sx[SW-1] && (f_sx[31:0] != 32'd0));
    qy = f_sy[SW-1:32] + QW'(f_sy[SW-1] && (f_sy[31:0] != 32'd0));
    out_x = qx[QW-1] || (qx >= QW'(MAP_WIDTH));
    out_y = qy[QW-1] || (qy >= QW'(MAP_HEIGHT));
    g_hit = !f_bad && !out_x && !out_y;
  end

  always_ff @(posedge clk) begin
    d_bad  <= cbad[STEPS];
    d_dist <= cdist[STEPS];
    d_c    <= cflip[STEPS] ? -cx[STEPS] : cx[STEPS];
    d_s    <= cflip[STEPS] ? -cy[STEPS] : cy[STEPS];

    e_bad  <= d_bad;
    e_px   <= $signed({1'b0, d_dist}) * d_c;
    e_py   <= $signed({1'b0, d_dist}) * d_s;

    f_bad  <= e_bad;
    f_sx   <= $signed({{(SW-48){offset_x[23]}}, offset_x, 24'b0}) +
              $signed({e_px[PW-1], e_px});
    f_sy   <= $signed({{(SW-48){offset_y[23]}}, offset_y, 24'b0}) +
              $signed({e_py[PW-1], e_py});

    if (f_bad) g_status <= lbgc_pkg::ST_INVALID;
    else if (!g_hit) g_status <= lbgc_pkg::ST_OUTSIDE;
    else g_status <= lbgc_pkg::ST_HIT;
    g_u <= g_hit ? qx[9:0] : 10'd0;
    g_v <= g_hit ? qy[9:0] : 10'd0;

    result.status     <= g_status;
    result.cell_x     <= g_u;
    result.cell_y     <= g_v;
    result.cell_index <= 20'({10'b0, g_v} * 20'(MAP_WIDTH)) + {10'b0, g_u};
  end

  `LBGC_ASSERT_DLY(a_latency, accept, LATENCY, done, "started beam gave no result")
  `LBGC_ASSERT_DLY(a_bad_beam, accept && beam.not_finite, LATENCY, done && result.status == lbgc_pkg::ST_INVALID, "non-finite beam not reported invalid")
  `LBGC_ASSERT_IMP(a_miss_zero, done && result.status != lbgc_pkg::ST_HIT, result.cell_x == 10'd0 && result.cell_y == 10'd0 && result.cell_index == 20'd0, "cell fields set on a miss")
  `LBGC_ASSERT_IMP(a_hit_range, done && result.status == lbgc_pkg::ST_HIT, result.cell_x < MAP_WIDTH && result.cell_y < MAP_HEIGHT, "hit outside the map")

endmodule
